/* sv/cwcm_pkg.sv */
// ---------------------------------------------------------------------------
// cwcm_pkg: shared types and constants
// Commands, widths and defaults for the complex window convolve block.
// ---------------------------------------------------------------------------
`default_nettype none
package cwcm_pkg;
  localparam int KERNEL_SIZE_DEF = 5;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int COEF_BITS_DEF   = 16;
  localparam int MAX_HEIGHT      = 1024;
  localparam int CFG_BITS        = 11;
  localparam int POS_BITS        = 13;
  localparam logic [7:0] SAT_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_PIXEL = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // Sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_SUM,
    S_MAG,
    S_OUT
  } state_t;

  // Phases of the magnitude unit
  typedef enum logic [1:0] {
    MP_IDLE,
    MP_RANGE,
    MP_SQUARE,
    MP_ROOT
  } mag_phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [4:0]  coef_index;
    logic signed [15:0] coef_real;
    logic signed [15:0] coef_imag;
    logic [7:0]  pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       frame_end;
  } out_item_t;

  // Controls sent from the sequencer to the cell row
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;
endpackage
`default_nettype wire

/* sv/cwcm_stream_if.sv */
// ---------------------------------------------------------------------------
// cwcm_stream_if: valid/ready channel
// Carries one payload of any packed type between a source and a sink.
// ---------------------------------------------------------------------------
`default_nettype none
interface cwcm_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

/* sv/cwcm_tap_cell.sv */
// ---------------------------------------------------------------------------
// cwcm_tap_cell: one window tap
// Holds one pixel and both coefficients, passes the pixel on when shifted,
// and adds its two products onto the partial sums handed down the chain.
// ---------------------------------------------------------------------------
`default_nettype none
module cwcm_tap_cell #(
  parameter int COEF_BITS = 16,
  parameter int ACC_BITS  = 40
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cwcm_pkg::cell_ctl_t         ctl,
  input  wire logic                        coef_sel,
  input  wire logic signed [COEF_BITS-1:0] coef_re_in,
  input  wire logic signed [COEF_BITS-1:0] coef_im_in,
  input  wire logic [7:0]                  pix_in,
  output logic [7:0]                       pix_out,
  input  wire logic signed [ACC_BITS-1:0]  sum_re_in,
  input  wire logic signed [ACC_BITS-1:0]  sum_im_in,
  output logic signed [ACC_BITS-1:0]       sum_re_out,
  output logic signed [ACC_BITS-1:0]       sum_im_out
);
  import cwcm_pkg::*;
  logic signed [COEF_BITS-1:0] coef_re, coef_im;
  logic signed [COEF_BITS+8:0] prod_re, prod_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out <= '0;
      coef_re <= '0;
      coef_im <= '0;
    end else begin
      if (ctl.shift) pix_out <= pix_in;
      if (ctl.load && coef_sel) begin
        coef_re <= coef_re_in;
        coef_im <= coef_im_in;
      end
    end
  end

  assign prod_re = coef_re * $signed({1'b0, pix_out});
  assign prod_im = coef_im * $signed({1'b0, pix_out});

  // Partial sums advance one cell per cycle
  always_ff @(posedge clk) begin
    sum_re_out <= sum_re_in + ACC_BITS'(prod_re);
    sum_im_out <= sum_im_in + ACC_BITS'(prod_im);
  end
endmodule
`default_nettype wire

/* sv/cwcm_magnitude.sv */
// ---------------------------------------------------------------------------
// cwcm_magnitude: clamped complex magnitude
// Squares the sums, then a bit-per-cycle integer square root of 8 steps.
// ---------------------------------------------------------------------------
`default_nettype none
module cwcm_magnitude #(
  parameter int ACC_BITS  = 40,
  parameter int FRAC_BITS = 14
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic signed [ACC_BITS-1:0] sum_re,
  input  wire logic signed [ACC_BITS-1:0] sum_im,
  output logic                            done,
  output logic [7:0]                      mag
);
  import cwcm_pkg::*;
  localparam int AB = FRAC_BITS + 8;
  localparam int SB = 2 * AB + 1;
  mag_phase_t phase, phase_next;
  logic [ACC_BITS-1:0] ar, ai;
  logic [AB-1:0] sq_a, sq_b;
  logic sat;
  logic [16:0] rad;
  logic [7:0]  root;
  logic [2:0]  bitpos;
  logic [7:0]  trial;
  logic [15:0] trial_sq;

  assign trial    = root | (8'd1 << bitpos);
  assign trial_sq = trial * trial;

  always_comb begin
    phase_next = phase;
    case (phase)
      MP_IDLE:   if (start) phase_next = MP_RANGE;
      MP_RANGE:  phase_next = MP_SQUARE;
      MP_SQUARE: phase_next = MP_ROOT;
      MP_ROOT:   if (bitpos == 3'd0) phase_next = MP_IDLE;
      default:   phase_next = MP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= MP_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= (phase == MP_ROOT) && (bitpos == 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      MP_IDLE: if (start) begin
        ar <= sum_re[ACC_BITS-1] ? ACC_BITS'(-sum_re) : sum_re;
        ai <= sum_im[ACC_BITS-1] ? ACC_BITS'(-sum_im) : sum_im;
      end
      MP_RANGE: begin
        sat  <= (ar >= (ACC_BITS'(256) << FRAC_BITS)) ||
                (ai >= (ACC_BITS'(256) << FRAC_BITS));
        sq_a <= ar[AB-1:0];
        sq_b <= ai[AB-1:0];
      end
      MP_SQUARE: begin
        rad    <= 17'((SB'(sq_a * sq_a) + SB'(sq_b * sq_b)) >> (2*FRAC_BITS));
        root   <= '0;
        bitpos <= 3'd7;
      end
      MP_ROOT: begin
        if ({1'b0, trial_sq} <= rad) root <= trial;
        if (bitpos == 3'd0)
          mag <= (sat || rad[16]) ? SAT_LEVEL :
                 (({1'b0, trial_sq} <= rad) ? trial : root);
        bitpos <= bitpos - 3'd1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* sv/complex_window_convolve_magnitude_unit.sv */
// ---------------------------------------------------------------------------
// complex_window_convolve_magnitude_unit: windowed complex filter magnitude
// Line store and a row of tap cells; clamped magnitude per centre pixel.
// ---------------------------------------------------------------------------
// channel  dir  payload
// in_ch    in   command, coef_index, coef_real, coef_imag, pixel_value
// out_ch   out  magnitude, frame_end
// cfg      in   cfg_we, cfg_index, cfg_data
// A load or a pixel that owes no result passes S_PUSH; an ignored item stays
// in S_IDLE. A pixel with a result goes on to S_SUM, a flush owing one
// goes straight there: the sums ripple through the cell row, then range
// check, squares and an 8-step square root. One item is in work at a time.
// rst is synchronous; the line store is not cleared (it only feeds borders).
// A result held on out_ch stalls input; the next transfer comes at the
// earliest in the cycle after the result is taken.
// ---------------------------------------------------------------------------
`default_nettype none
module complex_window_convolve_magnitude_unit #(
  parameter int KERNEL_SIZE = cwcm_pkg::KERNEL_SIZE_DEF,
  parameter int MAX_WIDTH   = cwcm_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS   = cwcm_pkg::COEF_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  cwcm_stream_if.sink   in_ch,
  cwcm_stream_if.source out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [cwcm_pkg::CFG_BITS-1:0] cfg_data
);
  import cwcm_pkg::*;
  localparam int HALF_K    = KERNEL_SIZE / 2;
  localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
  localparam int FRAC_BITS = COEF_BITS - 2;
  localparam int ACC_BITS  = COEF_BITS + 9 + $clog2(TAPS);
  localparam int XB        = $clog2(MAX_WIDTH);
  localparam int LB        = (KERNEL_SIZE - 1) * 8;
  localparam int DB        = 24;
  localparam int CB        = $clog2(TAPS + 2);

  state_t state, state_next;

  logic [CFG_BITS-1:0] frame_width, frame_height;
  logic [CFG_BITS-1:0] w_eff, h_eff;
  logic [CFG_BITS-1:0] in_col, in_row, out_col, out_row;
  logic [DB-1:0] owed;
  in_item_t item;
  logic [LB-1:0] line_mem [MAX_WIDTH];
  logic [LB-1:0] line_rd;
  logic [XB-1:0] xaddr;
  logic [XB-1:0] wr_addr;
  logic [7:0] col_pix [KERNEL_SIZE];
  logic [CB-1:0] cnt;
  logic border;
  logic mag_done;
  logic [7:0] mag_val;
  logic pix_emit;
  cell_ctl_t ctl;

  assign w_eff = (frame_width == 0) ? CFG_BITS'(1) :
                 (int'(frame_width) > MAX_WIDTH) ? CFG_BITS'(MAX_WIDTH) : frame_width;
  assign h_eff = (frame_height == 0) ? CFG_BITS'(1) :
                 (frame_height > CFG_BITS'(MAX_HEIGHT)) ? CFG_BITS'(MAX_HEIGHT) : frame_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CFG_BITS'(640);
      frame_height <= CFG_BITS'(480);
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) frame_width <= cfg_data;
      else frame_height <= cfg_data;
    end
  end

  assign in_ch.ready = (state == S_IDLE) && !out_ch.valid;
  wire take = in_ch.valid && in_ch.ready;
  wire at_start = (in_col == 0) && (in_row == 0);

  assign xaddr = (int'(in_col) >= MAX_WIDTH) ? XB'(MAX_WIDTH - 1) : XB'(in_col);

  // Hold the column address of the transfer for the write-back
  always_ff @(posedge clk) begin
    if (take) begin
      item    <= in_ch.payload;
      wr_addr <= xaddr;
    end
    line_rd <= line_mem[xaddr];
    if (ctl.shift)
      line_mem[wr_addr] <= {line_rd[LB-9:0], item.pixel_value};
  end

  // Column entering the window: oldest line on top, new pixel at bottom
  always_comb begin
    for (int k = 0; k < KERNEL_SIZE - 1; k++)
      col_pix[KERNEL_SIZE-2-k] = line_rd[k*8 +: 8];
    col_pix[KERNEL_SIZE-1] = item.pixel_value;
  end

  // Tap cells: row j shifts left, new column enters at the right
  logic [7:0] pix [TAPS];
  logic signed [ACC_BITS-1:0] sre [TAPS+1], sim [TAPS+1];
  assign sre[0] = '0;
  assign sim[0] = '0;
  genvar g;
  generate
    for (g = 0; g < TAPS; g++) begin : g_tap
      logic [7:0] src;
      if ((g % KERNEL_SIZE) == KERNEL_SIZE - 1) begin : g_edge
        assign src = col_pix[g / KERNEL_SIZE];
      end else begin : g_mid
        assign src = pix[g+1];
      end
      cwcm_tap_cell #(.COEF_BITS(COEF_BITS), .ACC_BITS(ACC_BITS)) u_cell (
        .clk, .rst, .ctl,
        .coef_sel(int'(item.coef_index) == g),
        .coef_re_in(COEF_BITS'($signed(item.coef_real))),
        .coef_im_in(COEF_BITS'($signed(item.coef_imag))),
        .pix_in(src), .pix_out(pix[g]),
        .sum_re_in(sre[g]), .sum_im_in(sim[g]),
        .sum_re_out(sre[g+1]), .sum_im_out(sim[g+1]));
    end
  endgenerate

  cwcm_magnitude #(.ACC_BITS(ACC_BITS), .FRAC_BITS(FRAC_BITS)) u_mag (
    .clk, .rst, .start(state == S_SUM && cnt == '0),
    .sum_re(sre[TAPS]), .sum_im(sim[TAPS]), .done(mag_done), .mag(mag_val));

  wire [DB-1:0] delay = DB'(HALF_K) * DB'(w_eff) + DB'(HALF_K);
  wire emit_pix   = (owed + DB'(1)) > delay;
  wire emit_flush = at_start && (owed != 0);

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: if (take) begin
        case (in_ch.payload.command)
          CMD_LOAD:  state_next = S_PUSH;
          CMD_PIXEL: state_next = S_PUSH;
          CMD_FLUSH: state_next = emit_flush ? S_SUM : S_IDLE;
          default:   state_next = S_IDLE;
        endcase
      end
      S_PUSH: begin
        if (item.command == CMD_LOAD) begin
          ctl.load = (int'(item.coef_index) < TAPS);
          state_next = S_IDLE;
        end else begin
          ctl.shift = 1'b1;
          state_next = pix_emit ? S_SUM : S_IDLE;
        end
      end
      S_SUM:   state_next = (cnt == '0) ? S_MAG : S_SUM;
      S_MAG:   state_next = mag_done ? S_OUT : S_MAG;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign border = (out_col < CFG_BITS'(HALF_K)) ||
                  (out_col + CFG_BITS'(HALF_K) > w_eff - 1'b1) ||
                  (out_row < CFG_BITS'(HALF_K)) ||
                  (out_row + CFG_BITS'(HALF_K) > h_eff - 1'b1);

  // Counters and the owed count
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col <= '0; in_row <= '0; out_col <= '0; out_row <= '0;
      owed <= '0; cnt <= '0; pix_emit <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (take && in_ch.payload.command == CMD_PIXEL) begin
        if (at_start) begin
          out_col <= '0; out_row <= '0;
          pix_emit <= DB'(1) > delay;
          owed <= DB'(1);
        end else begin
          pix_emit <= emit_pix;
          owed <= owed + DB'(1);
        end
        if (in_col + 1'b1 >= w_eff) begin
          in_col <= '0;
          in_row <= (in_row + 1'b1 >= h_eff) ? '0 : in_row + 1'b1;
        end else in_col <= in_col + 1'b1;
      end
      if (take) cnt <= CB'(TAPS + 1);
      else if (state == S_SUM && cnt != '0) cnt <= cnt - 1'b1;
      if (state == S_MAG && mag_done) begin
        out_ch.payload.magnitude <= border ? SAT_LEVEL : mag_val;
        out_ch.payload.frame_end <= (out_row == h_eff - 1'b1) && (out_col == w_eff - 1'b1);
        out_ch.valid <= 1'b1;
        owed <= owed - DB'(1);
        if (out_col + 1'b1 >= w_eff) begin
          out_col <= '0;
          out_row <= (out_row + 1'b1 >= h_eff) ? '0 : out_row + 1'b1;
        end else out_col <= out_col + 1'b1;
      end
    end
  end

  // Assertions
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
  a_owed_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_MAG && mag_done) |-> owed != 0)
    else $error("emit with nothing owed");
endmodule
`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: complex window convolve magnitude unit
// Streams raster frames, kernel loads and flushes through the block under
// random idle and stall patterns. Frame sizes and kernels are swept between
// phases. A scoreboard predicts every clamped magnitude and frame-end flag
// and compares each result against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;
  import cwcm_pkg::*;

  localparam int K      = KERNEL_SIZE_DEF;
  localparam int HK     = K / 2;
  localparam int TAPS   = K * K;
  localparam int MAXW   = MAX_WIDTH_DEF;
  localparam int FRAC   = COEF_BITS_DEF - 2;
  localparam int SETTLE = 60;

  class conv_scoreboard;
    byte unsigned line_mem[(K - 1) * MAXW];
    byte unsigned win[TAPS];
    int kre[TAPS];
    int kim[TAPS];
    int unsigned in_col, in_row, out_col, out_row, fw, fh, owed;
    out_item_t pending_q[$];
    int failures, checked, interior, border, frame_ends;

    function new();
      foreach (line_mem[i]) line_mem[i] = 0;
      foreach (win[i]) begin
        win[i] = 0;
        kre[i] = 0;
        kim[i] = 0;
      end
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      fw = 640; fh = 480; owed = 0;
      failures = 0; checked = 0; interior = 0; border = 0; frame_ends = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] v);
      if (idx == REG_WIDTH) fw = v;
      else fh = v;
    endfunction

    function int unsigned eff_w();
      return (fw == 0) ? 1 : (fw > MAXW) ? MAXW : fw;
    endfunction

    function int unsigned eff_h();
      return (fh == 0) ? 1 : (fh > MAX_HEIGHT) ? MAX_HEIGHT : fh;
    endfunction

    function void advance_pos(inout int unsigned c, inout int unsigned r,
                              input int unsigned w, input int unsigned h);
      c++;
      if (c >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end
    endfunction

    function logic [7:0] window_mag();
      longint re, im, ar, ai, sum;
      int unsigned root, t2;
      re = 0;
      im = 0;
      for (int t = 0; t < TAPS; t++) begin
        re += longint'(kre[t]) * longint'(win[t]);
        im += longint'(kim[t]) * longint'(win[t]);
      end
      ar = (re < 0) ? -re : re;
      ai = (im < 0) ? -im : im;
      if (ar >= (longint'(256) << FRAC) || ai >= (longint'(256) << FRAC)) return SAT_LEVEL;
      sum = (ar * ar + ai * ai) >>> (2 * FRAC);
      if (sum >= 65536) return SAT_LEVEL;
      root = 0;
      for (int b = 7; b >= 0; b--) begin
        t2 = root | (1 << b);
        if (longint'(t2 * t2) <= sum) root = t2;
      end
      return (root > 255) ? SAT_LEVEL : root[7:0];
    endfunction

    function void produce();
      int unsigned w, h;
      out_item_t e;
      w = eff_w();
      h = eff_h();
      if (out_col < HK || out_col + HK > w - 1 || out_row < HK || out_row + HK > h - 1) begin
        e.magnitude = SAT_LEVEL;
        border++;
      end else begin
        e.magnitude = window_mag();
        interior++;
      end
      e.frame_end = (out_row == h - 1 && out_col == w - 1);
      pending_q.push_back(e);
      advance_pos(out_col, out_row, w, h);
      owed--;
    endfunction

    function void shift_pixel(byte unsigned pix);
      int unsigned x;
      byte unsigned column[K];
      x = (in_col >= MAXW) ? MAXW - 1 : in_col;
      column[K-1] = pix;
      for (int k = 0; k < K - 1; k++) column[K-2-k] = line_mem[k * MAXW + x];
      for (int k = K - 2; k > 0; k--) line_mem[k * MAXW + x] = line_mem[(k - 1) * MAXW + x];
      line_mem[x] = pix;
      for (int j = 0; j < K; j++) begin
        for (int i = 0; i < K - 1; i++) win[j*K + i] = win[j*K + i + 1];
        win[j*K + K - 1] = column[j];
      end
    endfunction

    function void note_input(in_item_t it);
      bit at_start;
      int unsigned w, h;
      at_start = (in_col == 0 && in_row == 0);
      w = eff_w();
      h = eff_h();
      case (cmd_t'(it.command))
        CMD_LOAD: begin
          if (it.coef_index < TAPS) begin
            kre[it.coef_index] = int'($signed(it.coef_real));
            kim[it.coef_index] = int'($signed(it.coef_imag));
          end
        end
        CMD_PIXEL: begin
          if (at_start) begin
            owed = 0;
            out_col = 0;
            out_row = 0;
          end
          shift_pixel(it.pixel_value);
          advance_pos(in_col, in_row, w, h);
          owed++;
          if (owed > HK * w + HK) produce();
        end
        CMD_FLUSH: begin
          if (at_start && owed > 0) produce();
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (got.frame_end) frame_ends++;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: unexpected result magnitude=%0d frame_end=%0b",
                   got.magnitude, got.frame_end);
        return;
      end
      e = pending_q.pop_front();
      if (got.magnitude !== e.magnitude || got.frame_end !== e.frame_end) begin
        failures++;
        if (failures <= 10)
          $display("ERROR: result %0d: expected magnitude=%0d frame_end=%0b, got %0d/%0b",
                   checked, e.magnitude, e.frame_end, got.magnitude, got.frame_end);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  cwcm_stream_if #(.payload_t(in_item_t))  in_ch ();
  cwcm_stream_if #(.payload_t(out_item_t)) out_ch ();

  complex_window_convolve_magnitude_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  conv_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;
  int frames_run = 0;
  int unsigned cyc = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(30_000_000);
    $display("simulation failed");
    $finish;
  end

  // Receiver: sample transfers and stall on a rotating pattern
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
      case ((cyc >> 8) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= (cyc % 4 == 0);
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send(cmd_t c, logic [4:0] idx, logic [15:0] re, logic [15:0] im,
                      logic [7:0] px);
    in_item_t it;
    int gap;
    it.command = c;
    it.coef_index = idx;
    it.coef_real = re;
    it.coef_imag = im;
    it.pixel_value = px;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(it);
    items_sent++;
  endtask

  // Drop valid, drain every predicted result, then allow the block to finish
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Hold the write for one edge, then drop it and idle before the next one
  task automatic write_reg(reg_idx_t idx, logic [CFG_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coef(int flavor);
    case (flavor)
      0: return 16'(int'($urandom_range(0, 2047)) - 1024);
      1: return 16'($urandom);
      default: return 16'd0;
    endcase
  endfunction

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic load_kernel(int flavor);
    for (int i = 0; i < TAPS; i++)
      send(CMD_LOAD, 5'(i), pick_coef(flavor), pick_coef(flavor), 8'($urandom));
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: send(CMD_LOAD, 5'($urandom_range(TAPS, 31)), 16'($urandom), 16'($urandom),
              8'($urandom));
      1: send(CMD_LOAD, 5'($urandom_range(0, TAPS - 1)), pick_coef(0), pick_coef(0),
              8'($urandom));
      2: send(CMD_NONE, 5'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      default: send(CMD_FLUSH, 5'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
    endcase
  endtask

  task automatic feed_pixels(int n, bit noisy);
    for (int p = 0; p < n; p++) begin
      if (noisy && $urandom_range(0, 23) == 0) noise_item();
      send(CMD_PIXEL, 5'($urandom), 16'($urandom), 16'($urandom), pick_pixel());
    end
  endtask

  task automatic flush_tail(int n);
    repeat (n) send(CMD_FLUSH, 5'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  initial begin
    int w, h, npix;
    rst = 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_WIDTH;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: coefficient extremes, ignored indexes, idle command, empty flush
    send(CMD_LOAD, 5'd0, 16'h8000, 16'h7fff, 8'h00);
    send(CMD_LOAD, 5'd24, 16'h7fff, 16'h8000, 8'hff);
    send(CMD_LOAD, 5'd25, 16'hffff, 16'hffff, 8'hff);
    send(CMD_LOAD, 5'd31, 16'hffff, 16'hffff, 8'hff);
    send(CMD_NONE, 5'd31, 16'hffff, 16'hffff, 8'hff);
    send(CMD_FLUSH, 5'd0, 16'h0000, 16'h0000, 8'h00);
    settle();
    write_reg(REG_WIDTH, 11'd5);
    write_reg(REG_HEIGHT, 11'd5);
    for (int i = 0; i < TAPS; i++) send(CMD_PIXEL, 5'd0, 16'd0, 16'd0, (i % 2) ? 8'hff : 8'h00);
    flush_tail(2 * 5 + 4);
    settle();

    // Extremes: clamped width on a single row, single column with clamped height,
    // then an oversized frame cut short so the next setting lands mid-frame
    write_reg(REG_WIDTH, 11'h7ff);
    write_reg(REG_HEIGHT, 11'd0);
    load_kernel(0);
    feed_pixels(40, 1'b0);
    settle();
    write_reg(REG_WIDTH, 11'd0);
    write_reg(REG_HEIGHT, 11'h7ff);
    feed_pixels(40, 1'b0);
    flush_tail(8);
    settle();
    write_reg(REG_WIDTH, 11'd1024);
    write_reg(REG_HEIGHT, 11'h7ff);
    feed_pixels(40, 1'b1);
    settle();

    // Random frames; some cut short so the next setting lands mid-frame
    while (items_sent < 850) begin
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 14);
      h = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 8);
      write_reg(REG_WIDTH, 11'(w));
      write_reg(REG_HEIGHT, 11'(h));
      if ($urandom_range(0, 2) == 0) load_kernel($urandom_range(0, 5) == 0 ? 1 : 0);
      npix = w * h;
      if ($urandom_range(0, 5) == 0) begin
        feed_pixels($urandom_range(1, npix), 1'b1);
      end else begin
        feed_pixels(npix, 1'b1);
        if ($urandom_range(0, 7) == 0) feed_pixels($urandom_range(1, npix), 1'b1);
        else flush_tail(2 * w + 4);
      end
      frames_run++;
      settle();
    end

    settle();
    $display("checked %0d results (%0d interior, %0d border, %0d frame ends)",
             sb.checked, sb.interior, sb.border, sb.frame_ends);
    $display("%0d random frames, %0d predictions left over", frames_run, sb.pending_q.size());
    if (sb.failures == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* files.f */
sv/cwcm_pkg.sv
sv/cwcm_stream_if.sv
sv/cwcm_tap_cell.sv
sv/cwcm_magnitude.sv
sv/complex_window_convolve_magnitude_unit.sv
verif/testbench.sv
